// File: design/ntc_thermistor_beta_converter_assert.svh
// Assertion macros shared by the converter's checker
`ifndef NTC_THERMISTOR_BETA_CONVERTER_ASSERT_SVH
`define NTC_THERMISTOR_BETA_CONVERTER_ASSERT_SVH

// Same-cycle implication
`define NTC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define NTC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ntc_pkg.sv
// Package: widths, codes, sideband type and natural log table of the converter
package ntc_pkg;

    localparam int LOG_TABLE_BITS = 8;
    localparam int LN_TAB_LEN     = (1 << LOG_TABLE_BITS) + 1;
    localparam int IDX_W          = LOG_TABLE_BITS + 1;
    localparam int PROD_W         = 32;
    localparam int MANT_SH        = PROD_W - LOG_TABLE_BITS;
    localparam int K_W            = 5;
    localparam int LN_W           = 36;
    localparam int LQ_W           = 27;
    localparam int MV_W           = 12;
    localparam int CFG_W          = 20;
    localparam int CFG_IDX_W      = 3;
    localparam int RES_W          = 20;
    localparam int TN_W           = 9;
    localparam int BETA_W         = 14;
    localparam int T0_W           = 16;
    localparam int TB_W           = 30;
    localparam int NB_W           = 37;
    localparam int DBASE_W        = 41;
    localparam int D_W            = 46;
    localparam int NUM_W          = 64;
    localparam int DEN_W          = 48;
    localparam int A_W            = 64;
    localparam int B_W            = 48;
    localparam int Q_BITS         = 17;
    localparam int TEMP_W         = 18;
    localparam int S_TDATA_W      = 16;
    localparam int M_TDATA_W      = 24;

    localparam logic [MV_W-1:0]   MV_LO        = 12'd10;
    localparam logic [MV_W-1:0]   MV_HI        = 12'd3290;
    localparam logic [MV_W-1:0]   MV_FULL      = 12'd3300;
    localparam logic [15:0]       KELVIN_OFS   = 16'd27315;
    localparam logic [15:0]       FAHR_OFS     = 16'd16000;
    localparam logic [7:0]        CENTI_SCALE  = 8'd100;
    localparam logic [Q_BITS-1:0] CENTI_LIMIT  = 17'd99900;
    localparam logic [RES_W-1:0]  RS_RESET     = 20'd10000;
    localparam logic [RES_W-1:0]  RN_RESET     = 20'd10000;
    localparam logic [TN_W-1:0]   TN_RESET     = 9'd25;
    localparam logic [BETA_W-1:0] BETA_RESET   = 14'd3950;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SERIES_RES  = 3'd0,
        CFG_NOMINAL_RES = 3'd1,
        CFG_NOMINAL_TMP = 3'd2,
        CFG_BETA        = 3'd3,
        CFG_UNIT        = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        UNIT_CELSIUS    = 2'd0,
        UNIT_KELVIN     = 2'd1,
        UNIT_FAHRENHEIT = 2'd2
    } t_unit;

    typedef struct packed {
        logic valid;
        logic inval;
        logic dneg;
        logic neg;
        logic ovf;
    } t_side;

    typedef logic [31:0] t_ln_tab [LN_TAB_LEN];

    // shift-subtract quotient, elaboration only
    function automatic logic [63:0] f_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[63:0], num[j]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[j] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(1 + i/2^LOG_TABLE_BITS) in Q30 via atanh series
    function automatic t_ln_tab f_ln_tab();
        t_ln_tab     tab;
        logic [63:0] d;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        for (int i = 0; i < LN_TAB_LEN; i++) begin
            d    = 64'((1 << (LOG_TABLE_BITS + 1)) + i);
            z    = f_udiv(64'(i) << 30, d);
            z2   = (z * z) >> 30;
            term = z;
            sum  = '0;
            for (int k = 0; k < 24; k++) begin
                sum  = sum + f_udiv(term, 64'(2 * k + 1));
                term = (term * z2) >> 30;
            end
            tab[i] = 32'(sum << 1);
        end
        return tab;
    endfunction

    localparam t_ln_tab     LN_TAB  = f_ln_tab();
    localparam logic [31:0] LN2_Q30 = LN_TAB[LN_TAB_LEN-1];

endpackage

// File: design/ntc_ln.sv
// Three-stage natural log unit: MSB search, table lookup, interpolation (Q30)
module ntc_ln (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [ntc_pkg::PROD_W-1:0] i_n,
    output logic [ntc_pkg::LN_W-1:0]   o_ln
);
    import ntc_pkg::*;

    function automatic logic [K_W-1:0] f_msb(input logic [PROD_W-1:0] n);
        logic [K_W-1:0] k;
        k = '0;
        for (int b = 0; b < PROD_W; b++) begin
            if (n[b]) begin
                k = K_W'(b);
            end
        end
        return k;
    endfunction

    logic [PROD_W-1:0]          r_n;
    logic [K_W-1:0]             r_ka;
    logic [K_W-1:0]             r_kb;
    logic [31:0]                r_lo;
    logic [31:0]                r_diff;
    logic [MANT_SH-1:0]         r_rem;
    logic [LN_W-1:0]            r_ln;

    logic [PROD_W-1:0]          w_al;
    logic [PROD_W-1:0]          w_frac;
    logic [LOG_TABLE_BITS-1:0]  w_idx;
    logic [31:0]                w_lo;
    logic [31:0]                w_hi;
    logic [31+MANT_SH:0]        w_prod;
    logic [LN_W-1:0]            n_ln;

    assign w_al   = r_n << (K_W'(PROD_W - 1) - r_ka);
    assign w_frac = {w_al[PROD_W-2:0], 1'b0};
    assign w_idx  = w_frac[PROD_W-1 -: LOG_TABLE_BITS];
    assign w_lo   = LN_TAB[IDX_W'(w_idx)];
    assign w_hi   = LN_TAB[IDX_W'(w_idx) + IDX_W'(1)];
    assign w_prod = {{MANT_SH{1'b0}}, r_diff} * {32'b0, r_rem};
    assign n_ln   = LN_W'(r_kb) * LN_W'(LN2_Q30) + LN_W'(r_lo) + LN_W'(w_prod >> MANT_SH);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n    <= i_n;
            r_ka   <= f_msb(i_n);
            r_kb   <= r_ka;
            r_lo   <= w_lo;
            r_diff <= w_hi - w_lo;
            r_rem  <= w_frac[MANT_SH-1:0];
            r_ln   <= n_ln;
        end
    end

    assign o_ln = r_ln;

endmodule

// File: design/ntc_div.sv
// Pipelined restoring divider: one quotient bit per stage, sideband carried along
module ntc_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  ntc_pkg::t_side             i_side,
    input  logic [ntc_pkg::A_W-1:0]    i_a,
    input  logic [ntc_pkg::B_W-1:0]    i_b,
    output ntc_pkg::t_side             o_side,
    output logic [ntc_pkg::Q_BITS-1:0] o_q
);
    import ntc_pkg::*;

    t_side             r_side [Q_BITS];
    logic [A_W-1:0]    r_rem  [Q_BITS];
    logic [B_W-1:0]    r_b    [Q_BITS];
    logic [Q_BITS-1:0] r_q    [Q_BITS];

    for (genvar s = 0; s < Q_BITS; s++) begin : g_stage
        localparam int J = Q_BITS - 1 - s;

        t_side             w_side;
        logic [A_W-1:0]    w_rem;
        logic [B_W-1:0]    w_b;
        logic [Q_BITS-1:0] w_q;
        logic [A_W:0]      w_bs;
        logic              w_ge;

        if (s == 0) begin : g_first
            assign w_side = i_side;
            assign w_rem  = i_a;
            assign w_b    = i_b;
            assign w_q    = '0;
        end else begin : g_next
            assign w_side = r_side[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_b    = r_b[s-1];
            assign w_q    = r_q[s-1];
        end

        assign w_bs = (A_W+1)'(w_b) << J;
        assign w_ge = {1'b0, w_rem} >= w_bs;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_side[s] <= '0;
            end else if (i_en) begin
                r_side[s] <= w_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_b[s]   <= w_b;
                r_rem[s] <= w_ge ? A_W'({1'b0, w_rem} - w_bs) : w_rem;
                r_q[s]   <= w_q | (Q_BITS'(w_ge) << J);
            end
        end
    end

    assign o_side = r_side[Q_BITS-1];
    assign o_q    = r_q[Q_BITS-1];

endmodule

// File: design/ntc_thermistor_beta_converter.sv
// Top level: NTC thermistor Beta-equation temperature converter
//
// Slave stream takes one divider voltage in mV per item (tdata[11:0]).
// Master stream gives one result per item: tdata[17:0] is the signed
// temperature in hundredths of the selected unit, tuser is 1 for a voltage
// inside the usable window (11..3289 mV); outside it the result is -99900.
// Configuration registers (index 0..4: series resistor, nominal resistance,
// nominal temperature, Beta, unit) load through i_cfg_we/i_cfg_idx/i_cfg_data
// and must be written while no item is in flight.
// The pipeline has 27 register stages, from the input stage to the output
// register. One item is taken every cycle while the output is not stalled.
// The depth is set by two 3-stage log units and the 17-stage restoring
// divider that forms the rounded quotient.
// The whole pipeline advances when the output register is empty or taken;
// while the receiver stalls with a result pending, the pipeline holds and
// tready drops, so nothing is lost or repeated.
// Synchronous reset clears all valid bits and restores register defaults.
module ntc_thermistor_beta_converter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [11:0] divider_mv, [15:12] zero
    input  logic [ntc_pkg::S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [17:0] temperature_centi, [23:18] zero
    output logic [ntc_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    // [0] reading_valid
    output logic                          o_m_axis_tuser,
    input  logic                          i_cfg_we,
    input  logic [ntc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ntc_pkg::CFG_W-1:0]     i_cfg_data
);
    import ntc_pkg::*;

    // configuration
    logic [RES_W-1:0]         r_rs;
    logic [RES_W-1:0]         r_rn;
    logic signed [TN_W-1:0]   r_tn;
    logic [BETA_W-1:0]        r_beta;
    t_unit                    r_unit;
    logic [BETA_W-1:0]        r_beff;
    logic [T0_W-1:0]          r_t0;
    logic [TB_W-1:0]          r_tb;
    logic [NB_W-1:0]          r_nb;
    logic [DBASE_W-1:0]       r_dbase;
    logic signed [16:0]       w_t0s;

    // pipeline
    logic                     w_adv;
    t_side                    r_sd [1:9];
    t_side                    n_sd1;
    t_side                    n_sd8;
    t_side                    n_sd9;
    logic [MV_W-1:0]          w_mv;
    logic [RES_W-1:0]         w_rs_eff;
    logic [RES_W-1:0]         w_rn_eff;
    logic [PROD_W-1:0]        r1_p1;
    logic [PROD_W-1:0]        r1_p2;
    logic [LN_W-1:0]          w_ln1;
    logic [LN_W-1:0]          w_ln2;
    logic signed [LN_W:0]     w_l30;
    logic [LN_W:0]            w_l30_mag;
    logic [LN_W:0]            w_l30_rnd;
    logic signed [LQ_W-1:0]   n_lq;
    logic signed [LQ_W-1:0]   r5_lq;
    logic signed [D_W-1:0]    w_ld;
    logic signed [D_W-1:0]    r6_d;
    logic signed [NUM_W-1:0]  w_n;
    logic signed [NUM_W-1:0]  w_kd;
    logic signed [NUM_W-1:0]  r7_c;
    logic signed [D_W-1:0]    r7_d;
    logic signed [NUM_W-1:0]  n_num;
    logic signed [DEN_W-1:0]  n_den;
    logic signed [NUM_W-1:0]  r8_num;
    logic signed [DEN_W-1:0]  r8_den;
    logic [NUM_W-1:0]         w_num_mag;
    logic [A_W-1:0]           r9_a;
    logic [B_W-1:0]           r9_b;
    logic [A_W-1:0]           n_a;
    logic [B_W-1:0]           n_b;
    t_side                    w_div_side;
    logic [Q_BITS-1:0]        w_div_q;
    logic [Q_BITS-1:0]        w_mag;
    logic [TEMP_W-1:0]        n_temp;

    logic                     r_ov;
    logic [TEMP_W-1:0]        r_temp;
    logic                     r_user;

    assign w_adv = !r_ov || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs   <= RS_RESET;
            r_rn   <= RN_RESET;
            r_tn   <= TN_RESET;
            r_beta <= BETA_RESET;
            r_unit <= UNIT_CELSIUS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SERIES_RES:  r_rs   <= i_cfg_data[RES_W-1:0];
                CFG_NOMINAL_RES: r_rn   <= i_cfg_data[RES_W-1:0];
                CFG_NOMINAL_TMP: r_tn   <= i_cfg_data[TN_W-1:0];
                CFG_BETA:        r_beta <= i_cfg_data[BETA_W-1:0];
                CFG_UNIT:        r_unit <= t_unit'(i_cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    assign w_t0s = r_tn * $signed(CENTI_SCALE) + $signed({1'b0, KELVIN_OFS});

    always_ff @(posedge i_clk) begin
        r_beff  <= (r_beta == '0) ? BETA_W'(1) : r_beta;
        r_t0    <= w_t0s[T0_W-1:0];
        r_tb    <= TB_W'(r_t0) * TB_W'(r_beff);
        r_nb    <= NB_W'(r_tb) * NB_W'(CENTI_SCALE);
        r_dbase <= (DBASE_W'(r_beff) * DBASE_W'(CENTI_SCALE)) << 20;
    end

    // stage 1: window check and resistor products
    assign w_mv     = i_s_axis_tdata[MV_W-1:0];
    assign w_rs_eff = (r_rs == '0) ? RES_W'(1) : r_rs;
    assign w_rn_eff = (r_rn == '0) ? RES_W'(1) : r_rn;

    always_comb begin
        n_sd1       = '0;
        n_sd1.valid = i_s_axis_tvalid;
        n_sd1.inval = (w_mv <= MV_LO) || (w_mv >= MV_HI);
    end

    // stages 2-4: logarithms
    ntc_ln u_ln_num (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_n   (r1_p1),
        .o_ln  (w_ln1)
    );

    ntc_ln u_ln_den (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_n   (r1_p2),
        .o_ln  (w_ln2)
    );

    // stage 5: log ratio rounded to Q20
    assign w_l30     = $signed({1'b0, w_ln1}) - $signed({1'b0, w_ln2});
    assign w_l30_mag = w_l30[LN_W] ? (LN_W+1)'(-w_l30) : w_l30;
    assign w_l30_rnd = (w_l30_mag + (LN_W+1)'(512)) >> 10;
    assign n_lq      = w_l30[LN_W] ? -$signed(w_l30_rnd[LQ_W-1:0])
                                   : $signed(w_l30_rnd[LQ_W-1:0]);

    // stage 6: denominator
    assign w_ld = r5_lq * $signed({1'b0, r_t0});

    // stage 7: Celsius numerator
    assign w_n  = $signed({{(NUM_W-NB_W-20){1'b0}}, r_nb, 20'b0});
    assign w_kd = r6_d * $signed({1'b0, KELVIN_OFS});

    // stage 8: unit select
    always_comb begin
        n_sd8      = r_sd[7];
        n_sd8.dneg = (r7_d <= 0);
        case (r_unit)
            UNIT_KELVIN: begin
                n_num = r7_c + NUM_W'(r7_d) * $signed({1'b0, KELVIN_OFS});
                n_den = DEN_W'(r7_d);
            end
            UNIT_FAHRENHEIT: begin
                n_num = (r7_c <<< 3) + r7_c + NUM_W'(r7_d) * $signed({1'b0, FAHR_OFS});
                n_den = (DEN_W'(r7_d) <<< 2) + DEN_W'(r7_d);
            end
            default: begin
                n_num = r7_c;
                n_den = DEN_W'(r7_d);
            end
        endcase
    end

    // stage 9: rounding operands and range check
    assign w_num_mag = r8_num[NUM_W-1] ? NUM_W'(-r8_num) : NUM_W'(r8_num);
    assign n_a       = {w_num_mag[A_W-2:0], 1'b0} + A_W'(unsigned'(r8_den));
    assign n_b       = {r8_den[B_W-2:0], 1'b0};

    always_comb begin
        n_sd9     = r_sd[8];
        n_sd9.neg = r8_num[NUM_W-1];
        n_sd9.ovf = {1'b0, n_a} >= ((A_W+1)'(n_b) << Q_BITS);
    end

    // stages 10-26: quotient
    ntc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_side  (r_sd[9]),
        .i_a     (r9_a),
        .i_b     (r9_b),
        .o_side  (w_div_side),
        .o_q     (w_div_q)
    );

    // stage 27: sign, saturation, invalid marker
    assign w_mag = (w_div_side.ovf || (w_div_q > CENTI_LIMIT)) ? CENTI_LIMIT : w_div_q;

    always_comb begin
        if (w_div_side.inval) begin
            n_temp = -TEMP_W'(CENTI_LIMIT);
        end else if (w_div_side.dneg) begin
            n_temp = TEMP_W'(CENTI_LIMIT);
        end else if (w_div_side.neg) begin
            n_temp = -TEMP_W'(w_mag);
        end else begin
            n_temp = TEMP_W'(w_mag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sd <= '{default: '0};
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_sd[1] <= n_sd1;
            for (int s = 2; s <= 7; s++) begin
                r_sd[s] <= r_sd[s-1];
            end
            r_sd[8] <= n_sd8;
            r_sd[9] <= n_sd9;
            r_ov    <= w_div_side.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_p1  <= PROD_W'(w_rs_eff) * PROD_W'(MV_FULL - w_mv);
            r1_p2  <= PROD_W'(w_mv) * PROD_W'(w_rn_eff);
            r5_lq  <= n_lq;
            r6_d   <= $signed({{(D_W-DBASE_W){1'b0}}, r_dbase}) + w_ld;
            r7_c   <= w_n - w_kd;
            r7_d   <= r6_d;
            r8_num <= n_num;
            r8_den <= n_den;
            r9_a   <= n_a;
            r9_b   <= n_b;
            r_temp <= n_temp;
            r_user <= !w_div_side.inval;
        end
    end

    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {{(M_TDATA_W-TEMP_W){1'b0}}, r_temp};
    assign o_m_axis_tuser  = r_user;

endmodule

// File: design/ntc_checker.sv
// Port-level checker for the converter, bound to the top level
`include "ntc_thermistor_beta_converter_assert.svh"

module ntc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tuser
);

    `NTC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_m_axis_tvalid && !i_m_axis_tready,
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser),
        "stalled item changed")

    `NTC_ASSERT_IMPLY(a_ready_when_empty, i_clk, i_rst_n,
        !o_m_axis_tvalid, o_s_axis_tready, "input blocked with empty output")

    `NTC_ASSERT_IMPLY(a_invalid_marker, i_clk, i_rst_n,
        o_m_axis_tvalid && !o_m_axis_tuser, o_m_axis_tdata[17:0] == 18'h279C4,
        "invalid reading without marker value")

    `NTC_ASSERT_IMPLY(a_valid_range, i_clk, i_rst_n,
        o_m_axis_tvalid && o_m_axis_tuser,
        ($signed(o_m_axis_tdata[17:0]) <= 18'sd99900)
            && ($signed(o_m_axis_tdata[17:0]) >= -18'sd99900),
        "temperature outside saturation range")

endmodule

bind ntc_thermistor_beta_converter ntc_checker u_ntc_checker (.*);
